// ----- hdl/mdiom_pkg.sv -----
`default_nettype none
package mdiom_pkg;

  localparam int unsigned TA_FLUSH_BITS = 32;

  localparam logic [5:0] PREAMBLE_RESET = 6'd32;
  localparam logic [5:0] HDR_BITS = 6'd14;
  localparam logic [5:0] DATA_BITS = 6'd16;
  localparam logic [5:0] WTA_BITS = 6'd2;
  localparam logic [5:0] FLUSH_COUNT = 6'(TA_FLUSH_BITS);

  // phase codes
  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_PRE   = 4'd1;
  localparam logic [3:0] PH_HDR   = 4'd2;
  localparam logic [3:0] PH_WTA   = 4'd3;
  localparam logic [3:0] PH_WDATA = 4'd4;
  localparam logic [3:0] PH_TAIL  = 4'd5;
  localparam logic [3:0] PH_RTA   = 4'd6;
  localparam logic [3:0] PH_FLUSH = 4'd7;
  localparam logic [3:0] PH_RDATA = 4'd8;

  // frame opcodes
  localparam logic [1:0] OP_ADDR     = 2'd0;
  localparam logic [1:0] OP_WRITE    = 2'd1;
  localparam logic [1:0] OP_C22_READ = 2'd2;
  localparam logic [1:0] OP_C45_READ = 2'd3;

  localparam logic [16:0] TA_FAIL_RESULT = 17'h1FFFF;

  typedef struct packed {
    logic        mode;
    logic        op_write;
    logic        clause45;
    logic [4:0]  phy_addr;
    logic [4:0]  reg_addr;
    logic [15:0] c45_reg;
    logic [15:0] write_data;
    logic        mdio_in;
  } item_t;

  typedef struct packed {
    logic        ta_error;
    logic [15:0] read_data;
    logic        done_res;
    logic        busy_res;
    logic        clock_pulse;
    logic        mdio_drive;
    logic        mdio_out;
  } result_t;

  typedef struct packed {
    logic write;
    logic data_valid;
    logic [5:0] data;
  } cfg_t;

endpackage
`default_nettype wire

// ----- hdl/mdio_management_master.sv -----
// Latency: a result word is registered and presented in the cycle after its input word is accepted.
// Throughput: one input word per cycle; the frame state machine advances once
//   per word and the output register takes a new result whenever it is empty or drained.
// Reset: synchronous, active low; state idle, preamble length 32, no result pending.
// Every word, tick or start, yields exactly one result word.
`default_nettype none
module mdio_management_master
  import mdiom_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [0] op_write, [1] clause45, [6:2] phy_addr, [11:7] reg_addr,
  // [27:12] c45_reg, [43:28] write_data, [44] mdio_in, [47:45] zero
  input  wire logic [47:0] in_tdata,
  // [0] mode
  input  wire logic        in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [0] mdio_out, [1] mdio_drive, [2] clock_pulse, [3] busy_res,
  // [4] done_res, [20:5] read_data, [21] ta_error, [23:22] zero
  output logic [23:0]      out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [5:0]  cfg_data
);

  item_t   item;
  result_t result;
  result_t res_r;
  cfg_t    cfg;
  logic    step;
  logic    out_valid_r;

  assign item.mode       = in_tuser;
  assign item.op_write   = in_tdata[0];
  assign item.clause45   = in_tdata[1];
  assign item.phy_addr   = in_tdata[6:2];
  assign item.reg_addr   = in_tdata[11:7];
  assign item.c45_reg    = in_tdata[27:12];
  assign item.write_data = in_tdata[43:28];
  assign item.mdio_in    = in_tdata[44];

  assign cfg_ready      = 1'b1;
  assign cfg.write      = cfg_valid;
  assign cfg.data_valid = cfg_ready;
  assign cfg.data       = cfg_data;

  assign in_tready = !out_valid_r || out_tready;
  assign step      = in_tvalid && in_tready;

  mdiom_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, res_r.ta_error, res_r.read_data, res_r.done_res,
                       res_r.busy_res, res_r.clock_pulse, res_r.mdio_drive,
                       res_r.mdio_out};

endmodule
`default_nettype wire

// ----- hdl/mdiom_core.sv -----
`default_nettype none
module mdiom_core
  import mdiom_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    step,
  input  wire item_t   item,
  input  wire cfg_t    cfg,
  output result_t      result
);

  logic [5:0]  preamble_r;
  logic [3:0]  phase_r, phase_nxt;
  logic [5:0]  count_r, count_nxt;
  logic [15:0] shift_r, shift_nxt;
  logic [4:0]  phy_r, phy_nxt;
  logic [4:0]  reg_r, reg_nxt;
  logic [15:0] c45a_r, c45a_nxt;
  logic [15:0] data_r, data_nxt;
  logic        fl_wr_r, fl_wr_nxt;
  logic        fl_c45_r, fl_c45_nxt;
  logic        fl_addrf_r, fl_addrf_nxt;
  logic [16:0] capt_r, capt_nxt;

  logic [5:0]  bc;
  logic [5:0]  bc_dec;
  logic [3:0]  bit_idx;
  logic [1:0]  op;
  logic [15:0] hdr_word;
  logic [15:0] wr_word;
  logic        bit_o, drive_o, pulse_o, done_o;

  always_comb begin
    if (fl_addrf_r) op = OP_ADDR;
    else if (fl_wr_r) op = OP_WRITE;
    else if (fl_c45_r) op = OP_C45_READ;
    else op = OP_C22_READ;
    // start bits 01 for Clause 22, 00 for Clause 45
    hdr_word = {3'b000, ~fl_c45_r, op, phy_r, reg_r};
    wr_word  = fl_addrf_r ? c45a_r : data_r;
    bc       = (count_r == 6'd0) ? 6'd1 : count_r;
    bc_dec   = bc - 6'd1;
    bit_idx  = bc_dec[3:0];
  end

  always_comb begin
    phase_nxt    = phase_r;
    count_nxt    = count_r;
    shift_nxt    = shift_r;
    phy_nxt      = phy_r;
    reg_nxt      = reg_r;
    c45a_nxt     = c45a_r;
    data_nxt     = data_r;
    fl_wr_nxt    = fl_wr_r;
    fl_c45_nxt   = fl_c45_r;
    fl_addrf_nxt = fl_addrf_r;
    capt_nxt     = capt_r;
    bit_o        = 1'b0;
    drive_o      = 1'b0;
    pulse_o      = 1'b0;
    done_o       = 1'b0;

    if (item.mode) begin
      if (phase_r == PH_IDLE) begin
        fl_wr_nxt    = item.op_write;
        fl_c45_nxt   = item.clause45;
        fl_addrf_nxt = item.clause45;
        phy_nxt      = item.phy_addr;
        reg_nxt      = item.reg_addr;
        c45a_nxt     = item.c45_reg;
        data_nxt     = item.write_data;
        shift_nxt    = '0;
        if (preamble_r != 6'd0) begin
          phase_nxt = PH_PRE;
          count_nxt = preamble_r;
        end else begin
          phase_nxt = PH_HDR;
          count_nxt = HDR_BITS;
        end
      end
    end else if (phase_r != PH_IDLE) begin
      pulse_o   = 1'b1;
      count_nxt = bc;
      case (phase_r)
        PH_PRE: begin
          drive_o   = 1'b1;
          bit_o     = 1'b1;
          count_nxt = bc_dec;
          if (bc_dec == 6'd0) begin
            phase_nxt = PH_HDR;
            count_nxt = HDR_BITS;
          end
        end
        PH_HDR: begin
          drive_o   = 1'b1;
          bit_o     = hdr_word[bit_idx];
          count_nxt = bc_dec;
          if (bc_dec == 6'd0) begin
            if (fl_wr_r || fl_addrf_r) begin
              phase_nxt = PH_WTA;
              count_nxt = WTA_BITS;
            end else begin
              phase_nxt = PH_RTA;
              count_nxt = 6'd1;
            end
          end
        end
        PH_WTA: begin
          drive_o   = 1'b1;
          bit_o     = (bc == WTA_BITS);
          count_nxt = bc_dec;
          if (bc_dec == 6'd0) begin
            phase_nxt = PH_WDATA;
            count_nxt = DATA_BITS;
          end
        end
        PH_WDATA: begin
          drive_o   = 1'b1;
          bit_o     = wr_word[bit_idx];
          count_nxt = bc_dec;
          if (bc_dec == 6'd0) begin
            phase_nxt = PH_TAIL;
            count_nxt = 6'd1;
          end
        end
        PH_TAIL: begin
          if (fl_addrf_r) begin
            // address frame sent, start the data frame
            fl_addrf_nxt = 1'b0;
            if (preamble_r != 6'd0) begin
              phase_nxt = PH_PRE;
              count_nxt = preamble_r;
            end else begin
              phase_nxt = PH_HDR;
              count_nxt = HDR_BITS;
            end
          end else begin
            done_o    = 1'b1;
            capt_nxt  = fl_wr_r ? 17'd0 : {1'b0, shift_r};
            phase_nxt = PH_IDLE;
            count_nxt = 6'd0;
          end
        end
        PH_RTA: begin
          if (item.mdio_in) begin
            if (TA_FLUSH_BITS == 0) begin
              done_o    = 1'b1;
              capt_nxt  = TA_FAIL_RESULT;
              phase_nxt = PH_IDLE;
              count_nxt = 6'd0;
            end else begin
              phase_nxt = PH_FLUSH;
              count_nxt = FLUSH_COUNT;
            end
          end else begin
            phase_nxt = PH_RDATA;
            count_nxt = DATA_BITS;
            shift_nxt = '0;
          end
        end
        PH_FLUSH: begin
          count_nxt = bc_dec;
          if (bc_dec == 6'd0) begin
            done_o    = 1'b1;
            capt_nxt  = TA_FAIL_RESULT;
            phase_nxt = PH_IDLE;
          end
        end
        PH_RDATA: begin
          shift_nxt = {shift_r[14:0], item.mdio_in};
          count_nxt = bc_dec;
          if (bc_dec == 6'd0) begin
            phase_nxt = PH_TAIL;
            count_nxt = 6'd1;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
          count_nxt = 6'd0;
        end
      endcase
    end

    result.mdio_out    = bit_o;
    result.mdio_drive  = drive_o;
    result.clock_pulse = pulse_o;
    result.done_res    = done_o;
    result.busy_res    = (phase_nxt != PH_IDLE) || (!item.mode && phase_r != PH_IDLE);
    result.read_data   = capt_nxt[15:0];
    result.ta_error    = capt_nxt[16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      preamble_r <= PREAMBLE_RESET;
    end else if (cfg.write && cfg.data_valid) begin
      preamble_r <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      count_r    <= '0;
      shift_r    <= '0;
      phy_r      <= '0;
      reg_r      <= '0;
      c45a_r     <= '0;
      data_r     <= '0;
      fl_wr_r    <= 1'b0;
      fl_c45_r   <= 1'b0;
      fl_addrf_r <= 1'b0;
      capt_r     <= '0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      count_r    <= count_nxt;
      shift_r    <= shift_nxt;
      phy_r      <= phy_nxt;
      reg_r      <= reg_nxt;
      c45a_r     <= c45a_nxt;
      data_r     <= data_nxt;
      fl_wr_r    <= fl_wr_nxt;
      fl_c45_r   <= fl_c45_nxt;
      fl_addrf_r <= fl_addrf_nxt;
      capt_r     <= capt_nxt;
    end
  end

endmodule
`default_nettype wire
